[hw/rtl/fms_pkg.sv]
// Package for the flight mode supervisor: mode codes, stick thresholds,
// reset bits and controller states. No dependencies.
package fms_pkg;
    localparam int TimeBits      = 32;
    localparam int RefreshDivide = 4;
    localparam int PhaseBits     = 2;

    typedef enum logic [2:0] {
        M_SAFE   = 3'd0,
        M_ARMED  = 3'd1,
        M_FLYING = 3'd2,
        M_ALT    = 3'd3,
        M_POS    = 3'd4,
        M_AUTO   = 3'd5
    } t_mode;

    localparam logic [11:0] ThrLow     = 12'd1010;
    localparam logic [11:0] YawLeft    = 12'd1200;
    localparam logic [11:0] YawRight   = 12'd1800;
    localparam logic [11:0] ThrTakeoff = 12'd1040;
    localparam logic [11:0] ThrAltCut  = 12'd1050;
    localparam logic [11:0] AuxOn      = 12'd1500;
    localparam logic [10:0] GroundCm   = 11'd20;
    localparam logic [11:0] StickTop   = 12'd2000;

    localparam logic [2:0] RbPos = 3'b001;
    localparam logic [2:0] RbAlt = 3'b010;
    localparam logic [2:0] RbArm = 3'b100;

    localparam logic [1:0] MotNone  = 2'd0;
    localparam logic [1:0] MotStop  = 2'd1;
    localparam logic [1:0] MotWrite = 2'd2;

    localparam logic [2:0] CfgHover = 3'd0;
    localparam logic [2:0] CfgMinH  = 3'd1;
    localparam logic [2:0] CfgMaxH  = 3'd2;
    localparam logic [2:0] CfgKill  = 3'd3;
    localparam logic [2:0] CfgIdle  = 3'd4;
    localparam logic [2:0] CfgArm   = 3'd5;
    localparam logic [2:0] CfgLoss  = 3'd6;

    // Quotient width of the stick mapping divider.
    localparam int QBits = 24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIVIDE,
        S_FINISH,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decide;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_status;
endpackage

[hw/rtl/fms_ctrl.sv]
// Controller for the flight mode supervisor: sequences capture, mode
// decision, serial divide and result hand-off. Uses fms_pkg.
module fms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fms_pkg::t_cmd     o_cmd,
    input  fms_pkg::t_status  i_status
);
    import fms_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVIDE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[hw/rtl/fms_datapath.sv]
// Datapath for the flight mode supervisor: state registers, timers,
// mode decision, serial divider for the stick height and result registers.
// Uses fms_pkg.
module fms_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fms_pkg::t_cmd       i_cmd,
    output fms_pkg::t_status    o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic [11:0]         i_throttle_us,
    input  logic [11:0]         i_yaw_us,
    input  logic [11:0]         i_aux_alt_us,
    input  logic [11:0]         i_aux_pos_us,
    input  logic [10:0]         i_height_cm,
    input  logic [31:0]         i_now_ms,
    output logic [2:0]          o_mode,
    output logic                o_radio_lost,
    output logic [2:0]          o_loop_select,
    output logic [1:0]          o_motor_action,
    output logic [2:0]          o_reset_mask,
    output logic                o_alt_engage,
    output logic [10:0]         o_alt_setpoint_cm,
    output logic signed [11:0]  o_stick_offset_cm,
    output logic signed [12:0]  o_integral_preload,
    output logic                o_ramp_active,
    output logic [10:0]         o_ramp_base
);
    import fms_pkg::*;

    // Configuration registers.
    logic [10:0] r_hover, r_minh, r_maxh, r_kill, r_idle;
    logic [15:0] r_arm_hold;
    logic [31:0] r_loss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hover    <= 11'd1500;
            r_minh     <= 11'd30;
            r_maxh     <= 11'd300;
            r_kill     <= 11'd1050;
            r_idle     <= 11'd1100;
            r_arm_hold <= 16'd1000;
            r_loss     <= 32'd60000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgHover: r_hover    <= i_cfg_data[10:0];
                CfgMinH:  r_minh     <= i_cfg_data[10:0];
                CfgMaxH:  r_maxh     <= i_cfg_data[10:0];
                CfgKill:  r_kill     <= i_cfg_data[10:0];
                CfgIdle:  r_idle     <= i_cfg_data[10:0];
                CfgArm:   r_arm_hold <= i_cfg_data[15:0];
                CfgLoss:  r_loss     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured tick.
    logic [11:0] r_thr, r_yaw, r_aalt, r_apos;
    logic [10:0] r_h;
    logic [TimeBits-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_thr  <= i_throttle_us;
            r_yaw  <= i_yaw_us;
            r_aalt <= i_aux_alt_us;
            r_apos <= i_aux_pos_us;
            r_h    <= i_height_cm;
            r_now  <= TimeBits'(i_now_ms);
        end
    end

    // Persistent state.
    logic [2:0]           r_fmode, n_fmode;
    logic                 r_err, n_err;
    logic [TimeBits-1:0]  r_hold_start, n_hold_start, r_low_start, n_low_start;
    logic                 r_hold_run, n_hold_run, r_low_run, n_low_run;
    logic                 r_pos_test, n_pos_test, r_ramp, n_ramp;
    logic [PhaseBits-1:0] r_phase;

    // Per-tick results from the decision step.
    logic [2:0]  r_loops, n_loops, r_rst, n_rst;
    logic [1:0]  r_motor, n_motor;
    logic        r_engage, n_engage, r_ground, n_ground;
    logic [10:0] r_base, n_base;
    logic signed [12:0] r_preload, n_preload;

    // Sign-aware stick mapping operands.
    logic signed [12:0] thr_s, kill_s, den_s;
    logic signed [12:0] span_s;
    logic signed [25:0] num_s;
    assign thr_s  = signed'({1'b0, r_thr});
    assign kill_s = signed'({2'b0, r_kill});
    assign den_s  = signed'({1'b0, StickTop}) - kill_s;
    assign span_s = signed'({2'b0, r_maxh}) - signed'({2'b0, r_minh});
    assign num_s  = span_s * (thr_s - kill_s);

    // Timer elapsed values.
    logic [TimeBits-1:0] hold_el, low_el;
    assign hold_el = r_now - r_hold_start;
    assign low_el  = r_now - r_low_start;

    logic disarm_sticks, arm_sticks, write_slot;
    assign disarm_sticks = (r_thr < ThrLow) && (r_yaw > YawRight);
    assign arm_sticks    = (r_thr < ThrLow) && (r_yaw < YawLeft);
    assign write_slot    = (r_phase == '0);

    // Mode decision, mirroring the per-tick rules.
    always_comb begin
        logic hc_cond;
        logic hc_fire;
        logic engage;
        logic [2:0] fm;
        n_fmode = r_fmode; n_err = r_err; n_hold_start = r_hold_start;
        n_hold_run = r_hold_run; n_low_start = r_low_start; n_low_run = r_low_run;
        n_pos_test = r_pos_test; n_ramp = r_ramp;
        n_loops = '0; n_rst = '0; n_motor = MotNone; n_engage = 1'b0;
        n_ground = 1'b0; n_base = '0; n_preload = '0;
        hc_cond = 1'b0; hc_fire = 1'b0; engage = 1'b0;
        fm = (r_fmode > M_AUTO) ? M_SAFE : r_fmode;
        n_fmode = fm;

        // The hold condition for this mode, evaluated when hold logic runs.
        hc_cond = (fm == M_SAFE) ? arm_sticks : disarm_sticks;

        case (fm)
            M_SAFE, M_ARMED: begin
                n_motor = MotStop;
                if (fm == M_ARMED && r_thr > ThrTakeoff) begin
                    n_fmode = M_FLYING; n_low_run = 1'b0;
                end
                if (r_apos > AuxOn) begin
                    if (!r_pos_test) begin
                        n_rst = n_rst | RbPos;
                        n_pos_test = 1'b1;
                    end
                    n_loops = 3'b001;
                end else begin
                    n_pos_test = 1'b0;
                end
                hc_fire = 1'b1;
            end
            M_FLYING: begin
                if (r_aalt > AuxOn && r_apos > AuxOn) begin
                    n_fmode = M_AUTO; engage = 1'b1; n_rst = RbPos;
                end else if (r_aalt > AuxOn) begin
                    n_fmode = M_ALT; engage = 1'b1;
                end else if (r_apos > AuxOn) begin
                    n_fmode = M_POS; n_rst = RbPos;
                end else begin
                    n_loops = 3'b100;
                    if (write_slot) n_motor = MotWrite;
                    hc_fire = 1'b1;
                end
            end
            M_ALT: begin
                if (r_aalt < AuxOn || r_thr < ThrAltCut) begin
                    n_fmode = M_FLYING; n_ramp = 1'b0; n_rst = RbAlt;
                end else if (r_apos > AuxOn) begin
                    n_fmode = M_AUTO; n_rst = RbPos;
                end else begin
                    n_loops = 3'b110;
                    if (write_slot) n_motor = MotWrite;
                    hc_fire = 1'b1;
                end
            end
            M_POS: begin
                if (r_apos < AuxOn) begin
                    n_fmode = M_FLYING; n_rst = RbPos;
                end else if (r_aalt > AuxOn) begin
                    n_fmode = M_AUTO; engage = 1'b1;
                end else begin
                    n_loops = 3'b101;
                    if (write_slot) n_motor = MotWrite;
                    hc_fire = 1'b1;
                end
            end
            default: begin
                if (r_aalt < AuxOn) begin
                    n_fmode = M_POS; n_ramp = 1'b0; n_rst = RbAlt;
                end else if (r_apos < AuxOn) begin
                    n_fmode = M_ALT; n_rst = RbPos;
                end else if (r_thr < ThrAltCut) begin
                    n_fmode = M_FLYING; n_ramp = 1'b0; n_rst = RbPos | RbAlt;
                end else begin
                    n_loops = 3'b111;
                    if (write_slot) n_motor = MotWrite;
                    hc_fire = 1'b1;
                end
            end
        endcase

        // Stick hold timer.
        if (hc_fire) begin
            if (!hc_cond) begin
                n_hold_run = 1'b0;
            end else if (!r_hold_run) begin
                n_hold_run = 1'b1;
                n_hold_start = r_now;
            end else if (hold_el > TimeBits'(r_arm_hold)) begin
                n_hold_run = 1'b0;
                case (fm)
                    M_SAFE: begin
                        n_fmode = M_ARMED; n_err = 1'b0;
                        n_rst = n_rst | RbArm; n_pos_test = 1'b0;
                    end
                    M_ARMED: n_fmode = M_SAFE;
                    M_FLYING: begin
                        n_fmode = M_SAFE; n_motor = MotStop;
                    end
                    M_ALT: begin
                        n_fmode = M_SAFE; n_rst = n_rst | RbAlt; n_motor = MotStop;
                    end
                    M_POS: begin
                        n_fmode = M_SAFE; n_rst = n_rst | RbPos; n_motor = MotStop;
                    end
                    default: begin
                        n_fmode = M_SAFE; n_rst = n_rst | RbPos | RbAlt;
                        n_motor = MotStop;
                    end
                endcase
            end
        end

        // Radio loss timer, flying mode only.
        if (fm == M_FLYING && hc_fire) begin
            if (r_thr < ThrLow) begin
                if (!r_low_run) begin
                    n_low_run = 1'b1;
                    n_low_start = r_now;
                end
                if ((r_low_run ? low_el : '0) > TimeBits'(r_loss)) begin
                    n_fmode = M_ARMED; n_err = 1'b1; n_low_run = 1'b0;
                end
            end else begin
                n_low_run = 1'b0;
            end
        end

        // Altitude engage.
        if (engage) begin
            n_engage = 1'b1;
            if (r_h < GroundCm) begin
                n_ground = 1'b1; n_ramp = 1'b1; n_base = r_idle;
                n_rst = n_rst | RbAlt;
            end else begin
                n_ramp = 1'b0; n_base = r_hover;
                n_preload = thr_s - signed'({2'b0, r_hover});
            end
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [QBits-1:0]  r_q;
    logic [QBits:0]    r_rem;
    logic [11:0]       r_dmag;
    logic              r_qneg;
    logic [4:0]        r_cnt;
    logic              r_need_div;
    logic [QBits:0]    trial;
    logic [25:0]       num_mag;

    assign num_mag = num_s[25] ? 26'(-num_s) : 26'(num_s);
    assign trial   = {r_rem[QBits-1:0], r_q[QBits-1]} - {13'd0, r_dmag};

    assign o_status.need_div = n_engage && !n_ground;
    assign o_status.div_done = (r_cnt == 5'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_q    <= num_mag[QBits-1:0];
            r_rem  <= '0;
            r_dmag <= den_s[12] ? 12'(-den_s) : den_s[11:0];
            r_qneg <= num_s[25] ^ den_s[12];
            r_cnt  <= 5'(QBits);
            r_need_div <= (den_s != 0);
        end else if (i_cmd.div_step && r_cnt != 5'd0) begin
            if (!trial[QBits]) begin
                r_rem <= trial;
                r_q   <= {r_q[QBits-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[QBits-1:0], r_q[QBits-1]};
                r_q   <= {r_q[QBits-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Latch decision results and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmode <= M_SAFE; r_err <= 1'b0; r_hold_start <= '0;
            r_hold_run <= 1'b0; r_low_start <= '0; r_low_run <= 1'b0;
            r_pos_test <= 1'b0; r_ramp <= 1'b0; r_phase <= '0;
        end else if (i_cmd.decide) begin
            r_fmode <= n_fmode; r_err <= n_err; r_hold_start <= n_hold_start;
            r_hold_run <= n_hold_run; r_low_start <= n_low_start;
            r_low_run <= n_low_run; r_pos_test <= n_pos_test; r_ramp <= n_ramp;
            r_phase <= (r_phase == PhaseBits'(RefreshDivide - 1)) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_loops <= n_loops; r_rst <= n_rst; r_motor <= n_motor;
            r_engage <= n_engage; r_ground <= n_ground; r_base <= n_base;
            r_preload <= n_preload;
        end
    end

    // Final stick clamp and offset.
    logic signed [25:0] quo, stick;
    logic signed [25:0] lo_s, hi_s;
    assign quo   = !r_need_div ? '0 : (r_qneg ? -signed'({2'b0, r_q}) : signed'({2'b0, r_q}));
    assign lo_s  = signed'({15'd0, r_minh});
    assign hi_s  = signed'({15'd0, r_maxh});

    always_comb begin
        stick = lo_s + quo;
        if (stick < lo_s) stick = lo_s;
        if (stick > hi_s) stick = hi_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_mode             <= r_fmode;
            o_radio_lost       <= r_err;
            o_loop_select      <= r_loops;
            o_motor_action     <= r_motor;
            o_reset_mask       <= r_rst;
            o_alt_engage       <= r_engage;
            o_alt_setpoint_cm  <= r_engage ? r_h : '0;
            o_stick_offset_cm  <= (r_engage && !r_ground)
                                  ? 12'(signed'({15'd0, r_h}) - stick) : '0;
            o_integral_preload <= r_preload;
            o_ramp_active      <= r_ramp;
            o_ramp_base        <= r_base;
        end
    end
endmodule

[hw/rtl/flight_mode_supervisor.sv]
// Top level of the flight mode supervisor. Joins the controller and the
// datapath. Depends on fms_pkg, fms_ctrl and fms_datapath.
//
// Usage: one control tick enters as an input beat (i_in_valid, o_in_stall)
// carrying the four stick pulses, the lidar height and the millisecond time.
// One result beat leaves per tick (o_out_valid, i_out_stall) with the mode,
// error flag, loop selection, motor action, reset mask and, on an altitude
// engage, the set point, stick offset, preload and ramp base.
// The result passes through the decide and finish steps before it is valid;
// when an altitude hold engages above ground, a divide step comes between:
// the stick-to-height mapping runs a restoring divider that retires one quotient
// bit per cycle over 24 bits, until the controller sees the count run out.
// One tick is worked on at a time; the next is accepted in the cycle after the
// result beat is taken.
// Configuration writes (i_cfg_valid, o_cfg_ready, index, data) are always
// ready and should be made while the block is idle.
// Reset (synchronous, active low) puts the mode in safe, clears the timers
// and flags and loads the default register values. While the receiver
// stalls, the result holds and no new tick is accepted.
module flight_mode_supervisor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [11:0]        i_throttle_us,
    input  logic [11:0]        i_yaw_us,
    input  logic [11:0]        i_aux_alt_us,
    input  logic [11:0]        i_aux_pos_us,
    input  logic [10:0]        i_height_cm,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_mode,
    output logic               o_radio_lost,
    output logic [2:0]         o_loop_select,
    output logic [1:0]         o_motor_action,
    output logic [2:0]         o_reset_mask,
    output logic               o_alt_engage,
    output logic [10:0]        o_alt_setpoint_cm,
    output logic signed [11:0] o_stick_offset_cm,
    output logic signed [12:0] o_integral_preload,
    output logic               o_ramp_active,
    output logic [10:0]        o_ramp_base
);
    import fms_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    fms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    fms_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_throttle_us      (i_throttle_us),
        .i_yaw_us           (i_yaw_us),
        .i_aux_alt_us       (i_aux_alt_us),
        .i_aux_pos_us       (i_aux_pos_us),
        .i_height_cm        (i_height_cm),
        .i_now_ms           (i_now_ms),
        .o_mode             (o_mode),
        .o_radio_lost       (o_radio_lost),
        .o_loop_select      (o_loop_select),
        .o_motor_action     (o_motor_action),
        .o_reset_mask       (o_reset_mask),
        .o_alt_engage       (o_alt_engage),
        .o_alt_setpoint_cm  (o_alt_setpoint_cm),
        .o_stick_offset_cm  (o_stick_offset_cm),
        .o_integral_preload (o_integral_preload),
        .o_ramp_active      (o_ramp_active),
        .o_ramp_base        (o_ramp_base)
    );
endmodule

[hw/rtl/fms_checker.sv]
// Port-level checker for the flight mode supervisor, bound to the top level.
// Depends on fms_pkg for mode and motor codes.
module fms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_mode,
    input logic [1:0]  o_motor_action,
    input logic        o_alt_engage,
    input logic [10:0] o_alt_setpoint_cm
);
    import fms_pkg::*;

    // A stalled result beat holds its mode.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_mode))
        else $error("result changed while stalled");

    // No new tick is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted with result pending");

    // Motor writes never come with the safe mode; a radio loss fallback
    // may report a write together with the armed mode.
    a_mot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motor_action == MotWrite |-> o_mode != M_SAFE)
        else $error("motor write in safe mode");

    // The set point is zero unless hold engages.
    a_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_alt_engage |-> o_alt_setpoint_cm == '0)
        else $error("set point without engage");
endmodule

bind flight_mode_supervisor fms_checker u_fms_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_mode            (o_mode),
    .o_motor_action    (o_motor_action),
    .o_alt_engage      (o_alt_engage),
    .o_alt_setpoint_cm (o_alt_setpoint_cm)
);

[test/tb.sv]
// Testbench for flight_mode_supervisor: drives control ticks and register writes,
// and checks every result beat against a behavioral predictor kept in a scoreboard.
// Depends on fms_pkg and the flight_mode_supervisor RTL.
`timescale 1ns / 1ps

module tb;
    import fms_pkg::*;

    typedef struct {
        logic [11:0] thr;
        logic [11:0] yaw;
        logic [11:0] aux_alt;
        logic [11:0] aux_pos;
        logic [10:0] height;
        logic [31:0] now;
    } t_tick;

    typedef struct {
        logic [2:0]  mode;
        logic        lost;
        logic [2:0]  loops;
        logic [1:0]  motor;
        logic [2:0]  rmask;
        logic        engage;
        logic [10:0] setpoint;
        logic [11:0] offset;
        logic [12:0] preload;
        logic        ramp;
        logic [10:0] base;
    } t_verdict;

    // Scoreboard: tracks supervisor state, predicts each tick's verdict and checks results.
    class supervisor_scoreboard;
        int hover, min_h, max_h, kill, idle, arm_hold;
        bit [31:0] loss_ms;
        t_mode mode;
        bit lost, hold_run, low_run, pos_on, ramp;
        bit [31:0] hold_start, low_start;
        int phase;
        t_verdict v;
        t_verdict due[$];
        int errors;

        function new();
            hover = 1500; min_h = 30; max_h = 300; kill = 1050; idle = 1100;
            arm_hold = 1000; loss_ms = 60000;
            mode = M_SAFE;
            lost = 0; hold_run = 0; low_run = 0; pos_on = 0; ramp = 0;
            hold_start = 0; low_start = 0; phase = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] index, logic [31:0] data);
            case (index)
                CfgHover: hover = data[10:0];
                CfgMinH:  min_h = data[10:0];
                CfgMaxH:  max_h = data[10:0];
                CfgKill:  kill = data[10:0];
                CfgIdle:  idle = data[10:0];
                CfgArm:   arm_hold = data[15:0];
                CfgLoss:  loss_ms = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Stick hold timer; true once the hold has lasted strictly longer than arm_hold.
        function bit hold_done(bit cond, bit [31:0] now);
            bit [31:0] span;
            if (!cond) begin
                hold_run = 0;
                return 0;
            end
            if (!hold_run) begin
                hold_run = 1;
                hold_start = now;
                return 0;
            end
            span = now - hold_start;
            if (span > arm_hold) begin
                hold_run = 0;
                return 1;
            end
            return 0;
        endfunction

        function void pos_test(logic [11:0] apos);
            if (apos > AuxOn) begin
                if (!pos_on) begin
                    v.rmask |= RbPos;
                    pos_on = 1;
                end
                v.loops |= 3'b001;
            end else begin
                pos_on = 0;
            end
        endfunction

        // Altitude hold engage: capture the set point, or start the ramp on the ground.
        function void engage_alt(t_tick t);
            longint lo, hi, den, num, stick;
            v.engage = 1;
            v.setpoint = t.height;
            if (t.height < GroundCm) begin
                ramp = 1;
                v.base = 11'(idle);
                v.offset = 0;
                v.rmask |= RbAlt;
            end else begin
                lo = min_h;
                hi = max_h;
                den = 2000 - kill;
                num = (hi - lo) * (longint'(t.thr) - kill);
                stick = lo + ((den != 0) ? num / den : 0);
                if (stick < lo) stick = lo;
                if (stick > hi) stick = hi;
                ramp = 0;
                v.base = 11'(hover);
                v.offset = 12'(longint'(t.height) - stick);
                v.preload = 13'(longint'(t.thr) - hover);
            end
        endfunction

        // Advances the supervisor by one accepted tick and queues its verdict.
        function void note_tick(t_tick t);
            bit write_slot, disarm;
            bit [31:0] span;
            write_slot = (phase == 0);
            disarm = (t.thr < ThrLow) && (t.yaw > YawRight);
            v = '{default: 0};
            case (mode)
                M_SAFE: begin
                    v.motor = MotStop;
                    pos_test(t.aux_pos);
                    if (hold_done(t.thr < ThrLow && t.yaw < YawLeft, t.now)) begin
                        mode = M_ARMED;
                        lost = 0;
                        v.rmask |= RbArm;
                        pos_on = 0;
                    end
                end
                M_ARMED: begin
                    v.motor = MotStop;
                    if (t.thr > ThrTakeoff) begin
                        mode = M_FLYING;
                        low_run = 0;
                    end
                    pos_test(t.aux_pos);
                    if (hold_done(disarm, t.now)) mode = M_SAFE;
                end
                M_FLYING: begin
                    if (t.aux_alt > AuxOn && t.aux_pos > AuxOn) begin
                        mode = M_AUTO;
                        engage_alt(t);
                        v.rmask |= RbPos;
                    end else if (t.aux_alt > AuxOn) begin
                        mode = M_ALT;
                        engage_alt(t);
                    end else if (t.aux_pos > AuxOn) begin
                        mode = M_POS;
                        v.rmask |= RbPos;
                    end else begin
                        v.loops = 3'b100;
                        if (write_slot) v.motor = MotWrite;
                        if (hold_done(disarm, t.now)) begin
                            mode = M_SAFE;
                            v.motor = MotStop;
                        end
                        // Radio loss: low throttle held too long in flight falls back to armed.
                        if (t.thr < ThrLow) begin
                            if (!low_run) begin
                                low_run = 1;
                                low_start = t.now;
                            end
                            span = t.now - low_start;
                            if (span > loss_ms) begin
                                mode = M_ARMED;
                                lost = 1;
                                low_run = 0;
                            end
                        end else begin
                            low_run = 0;
                        end
                    end
                end
                M_ALT: begin
                    if (t.aux_alt < AuxOn || t.thr < ThrAltCut) begin
                        mode = M_FLYING;
                        ramp = 0;
                        v.rmask |= RbAlt;
                    end else if (t.aux_pos > AuxOn) begin
                        mode = M_AUTO;
                        v.rmask |= RbPos;
                    end else begin
                        v.loops = 3'b110;
                        if (write_slot) v.motor = MotWrite;
                        if (hold_done(disarm, t.now)) begin
                            mode = M_SAFE;
                            v.rmask |= RbAlt;
                            v.motor = MotStop;
                        end
                    end
                end
                M_POS: begin
                    if (t.aux_pos < AuxOn) begin
                        mode = M_FLYING;
                        v.rmask |= RbPos;
                    end else if (t.aux_alt > AuxOn) begin
                        mode = M_AUTO;
                        engage_alt(t);
                    end else begin
                        v.loops = 3'b101;
                        if (write_slot) v.motor = MotWrite;
                        if (hold_done(disarm, t.now)) begin
                            mode = M_SAFE;
                            v.rmask |= RbPos;
                            v.motor = MotStop;
                        end
                    end
                end
                default: begin
                    if (t.aux_alt < AuxOn) begin
                        mode = M_POS;
                        ramp = 0;
                        v.rmask |= RbAlt;
                    end else if (t.aux_pos < AuxOn) begin
                        mode = M_ALT;
                        v.rmask |= RbPos;
                    end else if (t.thr < ThrAltCut) begin
                        mode = M_FLYING;
                        ramp = 0;
                        v.rmask |= RbPos | RbAlt;
                    end else begin
                        v.loops = 3'b111;
                        if (write_slot) v.motor = MotWrite;
                        if (hold_done(disarm, t.now)) begin
                            mode = M_SAFE;
                            v.rmask |= RbPos | RbAlt;
                            v.motor = MotStop;
                        end
                    end
                end
            endcase
            phase = (phase + 1) % RefreshDivide;
            v.mode = mode;
            v.lost = lost;
            v.ramp = ramp;
            due.push_back(v);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_verdict got);
            t_verdict want;
            if (due.size() == 0) begin
                report("result beat with no tick waiting");
                return;
            end
            want = due.pop_front();
            compare("mode", got.mode, want.mode);
            compare("radio_lost", got.lost, want.lost);
            compare("loop_select", got.loops, want.loops);
            compare("motor_action", got.motor, want.motor);
            compare("reset_mask", got.rmask, want.rmask);
            compare("alt_engage", got.engage, want.engage);
            compare("alt_setpoint_cm", got.setpoint, want.setpoint);
            compare("stick_offset_cm", got.offset, want.offset);
            compare("integral_preload", got.preload, want.preload);
            compare("ramp_active", got.ramp, want.ramp);
            compare("ramp_base", got.base, want.base);
        endtask
    endclass

    localparam int CycleLimit = 600000;
    localparam int SettleCycles = 40;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    logic i_in_valid, o_in_stall;
    logic [11:0] i_throttle_us, i_yaw_us, i_aux_alt_us, i_aux_pos_us;
    logic [10:0] i_height_cm;
    logic [31:0] i_now_ms;
    logic o_out_valid, i_out_stall;
    logic [2:0] o_mode, o_loop_select, o_reset_mask;
    logic o_radio_lost, o_alt_engage, o_ramp_active;
    logic [1:0] o_motor_action;
    logic [10:0] o_alt_setpoint_cm, o_ramp_base;
    logic signed [11:0] o_stick_offset_cm;
    logic signed [12:0] o_integral_preload;

    supervisor_scoreboard sb;
    bit calm;
    bit [31:0] clock_ms;
    int cycles;

    flight_mode_supervisor dut (.*);

    // Clock: 20 ns period.
    initial i_clk = 0;
    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("flight_mode_supervisor test failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (calm) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    // Result side: random stall, then take and check one result beat.
    initial begin
        int n;
        t_verdict got;
        i_out_stall = 1'b1;
        wait (sb != null);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.mode = o_mode;
            got.lost = o_radio_lost;
            got.loops = o_loop_select;
            got.motor = o_motor_action;
            got.rmask = o_reset_mask;
            got.engage = o_alt_engage;
            got.setpoint = o_alt_setpoint_cm;
            got.offset = o_stick_offset_cm;
            got.preload = o_integral_preload;
            got.ramp = o_ramp_active;
            got.base = o_ramp_base;
            sb.check_result(got);
        end
    end

    // Sends one tick beat after a random gap; a zero gap keeps valid high.
    task send_tick(t_tick t);
        int n;
        n = draw_wait();
        @(negedge i_clk);
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_throttle_us = t.thr;
        i_yaw_us = t.yaw;
        i_aux_alt_us = t.aux_alt;
        i_aux_pos_us = t.aux_pos;
        i_height_cm = t.height;
        i_now_ms = t.now;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_tick(t);
    endtask

    task send(int thr, int yaw, int aalt, int apos, int h, bit [31:0] now);
        t_tick t;
        t.thr = 12'(thr);
        t.yaw = 12'(yaw);
        t.aux_alt = 12'(aalt);
        t.aux_pos = 12'(apos);
        t.height = 11'(h);
        t.now = now;
        send_tick(t);
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] index, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task load_regs(int hov, int mn, int mx, int kl, int idl, int arm, bit [31:0] loss);
        write_reg(CfgHover, hov);
        write_reg(CfgMinH, mn);
        write_reg(CfgMaxH, mx);
        write_reg(CfgKill, kl);
        write_reg(CfgIdle, idl);
        write_reg(CfgArm, arm);
        write_reg(CfgLoss, loss);
    endtask

    function automatic int pick_aux();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1501, 2500);
            4, 5, 6, 7: return $urandom_range(0, 1499);
            8: return 1500;
            default: return $urandom_range(0, 2500);
        endcase
    endfunction

    // Builds a tick suited to the predicted mode so most runs get airborne.
    function automatic t_tick next_tick();
        t_tick t;
        int r;
        r = $urandom_range(0, 19);
        if (r < 17) clock_ms += $urandom_range(0, 600);
        else if (r < 19) clock_ms += 0;
        else clock_ms += $urandom;
        t.now = clock_ms;
        t.aux_alt = 12'(pick_aux());
        t.aux_pos = 12'(pick_aux());
        t.height = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 25))
                                               : 11'($urandom_range(0, 1500));
        r = $urandom_range(0, 19);
        if (r < 5) t.thr = 12'($urandom_range(0, 1009));
        else if (r < 8) t.thr = 12'($urandom_range(1005, 1060));
        else t.thr = 12'($urandom_range(1040, 2500));
        r = $urandom_range(0, 19);
        if (r < 3) t.yaw = 12'($urandom_range(1801, 2500));
        else if (r < 5) t.yaw = 12'($urandom_range(0, 1199));
        else t.yaw = 12'($urandom_range(0, 2500));
        if (sb.mode == M_SAFE && $urandom_range(0, 9) < 7) begin
            t.thr = 12'($urandom_range(0, 1009));
            t.yaw = 12'($urandom_range(0, 1199));
        end else if (sb.mode == M_ARMED && $urandom_range(0, 1) == 0) begin
            t.thr = 12'($urandom_range(1041, 2500));
        end else if (sb.mode != M_SAFE && $urandom_range(0, 29) == 0) begin
            t.thr = 12'($urandom_range(0, 1009));
            t.yaw = 12'($urandom_range(1801, 2500));
        end
        return t;
    endfunction

    task random_ticks(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) drain();
            send_tick(next_tick());
        end
        calm = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_throttle_us = '0;
        i_yaw_us = '0;
        i_aux_alt_us = '0;
        i_aux_pos_us = '0;
        i_height_cm = '0;
        i_now_ms = '0;
        calm = 0;
        clock_ms = 0;
        cycles = 0;
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults written back explicitly, then the directed walk through the modes.
        load_regs(1500, 30, 300, 1050, 1100, 1000, 60000);
        send(2500, 2500, 2500, 2500, 1500, 32'hFFFF_FFFF);
        send(0, 0, 0, 2501, 0, 32'hFFFF_FF00);
        send(0, 0, 0, 0, 0, 32'h0000_02E8);     // hold spans the time wrap, exactly at limit
        send(0, 0, 0, 0, 0, 32'h0000_02E9);     // one past the limit: arms
        send(1041, 1500, 0, 0, 100, 1000);      // takeoff
        send(1500, 1500, 0, 0, 100, 1001);
        send(1500, 1500, 2000, 0, 10, 1002);    // altitude engage on the ground
        send(1500, 1500, 0, 0, 10, 1003);
        send(1500, 1500, 2000, 0, 500, 1004);   // engage above ground
        send(1049, 1500, 2000, 0, 500, 1005);   // throttle cut leaves hold
        send(1500, 1500, 0, 2000, 500, 1006);   // position hold
        send(1500, 1500, 2000, 2000, 40, 1007); // auto position via engage
        send(1500, 1500, 1500, 2000, 40, 1008);
        send(1500, 1500, 2000, 2000, 1500, 1009);
        send(2000, 1500, 2000, 2000, 1500, 1010);
        send(1000, 1500, 2000, 2000, 1500, 1011);
        send(1500, 1500, 2000, 2000, 20, 1012);
        send(1500, 1500, 0, 0, 20, 1013);
        send(0, 2500, 0, 0, 20, 1014);          // disarm sticks in flight
        send(0, 2500, 0, 0, 20, 3000);
        send(0, 0, 0, 0, 0, 3001);
        send(4095, 4095, 4095, 4095, 2047, 3002);
        drain();

        random_ticks(260);
        drain();
        load_regs(1000, 0, 1500, 1000, 2000, 0, 0);
        random_ticks(260);
        drain();
        load_regs(2000, 1500, 0, 1999, 1000, 65535, 32'hFFFF_FFFF);
        random_ticks(260);
        drain();
        load_regs($urandom_range(1000, 2000), $urandom_range(0, 1500),
                  $urandom_range(0, 1500), $urandom_range(1000, 1999),
                  $urandom_range(1000, 2000), $urandom_range(0, 3000),
                  $urandom_range(0, 20000));
        random_ticks(260);
        drain();

        if (sb.errors == 0)
            $display("flight_mode_supervisor test passed");
        else
            $display("flight_mode_supervisor test failed");
        $finish;
    end
endmodule
